// ----- rtl/core/fct_pkg.sv -----
// Package for the frustum culling tester: opcodes, store geometry, and the
// lane control and status types. Depends on nothing.
package fct_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int COEF_COUNT  = 4;
	localparam int DATA_W      = 32;
	localparam int RAD_W       = 31;
	localparam int SLOT_W      = 5;
	localparam int OP_W        = 3;
	localparam int PIDX_W      = $clog2(PLANE_COUNT);
	localparam int PROD_W      = 2 * DATA_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int OFS_W       = DATA_W + 2;
	localparam int FRAC_W      = 16;
	localparam int ACC_W       = SUM_W + 2;
	localparam int TDATA_IN_W  = 264;
	localparam int TDATA_OUT_W = 8;

	// Coefficient position within one plane.
	localparam int COEF_A = 0;
	localparam int COEF_B = 1;
	localparam int COEF_C = 2;
	localparam int COEF_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 3'd0,
		OP_BOX     = 3'd1,
		OP_SPH_OVL = 3'd2,
		OP_SPH_IN  = 3'd3,
		OP_POINT   = 3'd4
	} op_t;

	typedef struct packed {
		logic en_s2;   // load product stage
		logic en_s3;   // load sum stage
		logic box_s2;  // take the larger product per axis
		logic r_add;   // add radius into offset (item in stage 1)
		logic r_sub;   // subtract radius from offset (item in stage 1)
	} lane_ctrl_t;

	typedef struct packed {
		logic neg;     // plane distance below zero
		logic zero;    // plane distance exactly zero
	} lane_stat_t;

endpackage

// ----- rtl/core/frustum_culling_tester.sv -----
// Top level of the frustum culling tester: stream ports, plane coefficient
// store, stage control and result register. Depends on fct_pkg, fct_plane_lane.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+--------------------------------------
//   s_*      | in  | s_tvalid/s_tready | tuser opcode, tdata operands, tlast
//   m_*      | out | m_tvalid/m_tready | tuser test kind, tdata pass, tlast
//
// Take one item per cycle while the stages can advance; a test item passes through
// the input register, product register, sum register and result register in turn.
// The products, one 32x32 multiplier pair per axis per plane, set the stage split.
// Write items and unused opcodes produce no result; a write lands in the store
// at its accept edge, so any later test sees it. Reset clears the store to zero
// and empties every stage. A stalled output holds; stages fill bubbles first,
// so input keeps flowing until every stage holds an item.
module frustum_culling_tester (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [4:0] slot, [36:5] coef_value, [68:37] ax, [100:69] ay, [132:101] az,
	// [164:133] bx, [196:165] by, [228:197] bz, [259:229] radius, rest zero
	input  logic [fct_pkg::TDATA_IN_W-1:0]       s_tdata,
	// [2:0] opcode
	input  logic [fct_pkg::OP_W-1:0]             s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] passed, rest zero
	output logic [fct_pkg::TDATA_OUT_W-1:0]      m_tdata,
	// [2:0] test_kind
	output logic [fct_pkg::OP_W-1:0]             m_tuser,
	output logic                                 m_tlast
);
	import fct_pkg::*;

	// Unpack the input payload.
	logic        [SLOT_W-1:0] in_slot;
	logic signed [DATA_W-1:0] in_coef;
	logic signed [DATA_W-1:0] in_lo [3];
	logic signed [DATA_W-1:0] in_hi [3];
	logic        [RAD_W-1:0]  in_rad;

	assign in_slot  = s_tdata[4:0];
	assign in_coef  = s_tdata[36:5];
	assign in_lo[0] = s_tdata[68:37];
	assign in_lo[1] = s_tdata[100:69];
	assign in_lo[2] = s_tdata[132:101];
	assign in_hi[0] = s_tdata[164:133];
	assign in_hi[1] = s_tdata[196:165];
	assign in_hi[2] = s_tdata[228:197];
	assign in_rad   = s_tdata[259:229];

	// Stage registers.
	logic                     v_s1, v_s2, v_s3, out_v_q;
	op_t                      op_s1, op_s2, op_s3;
	logic                     last_s1, last_s2, last_s3;
	logic signed [DATA_W-1:0] lo_s1 [3];
	logic signed [DATA_W-1:0] hi_s1 [3];
	logic        [RAD_W-1:0]  rad_s1;
	logic                     pass_q;
	op_t                      kind_q;
	logic                     last_q;

	logic signed [DATA_W-1:0] store_q [PLANE_COUNT][COEF_COUNT];

	logic en_out, en3, en2, en1;
	logic in_fire, is_write, is_test;
	logic [SLOT_W-3:0] slot_plane;

	// Advance a stage when it is empty or its successor advances.
	assign en_out = !out_v_q || m_tready;
	assign en3    = !v_s3 || en_out;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign s_tready = en1;

	assign in_fire  = s_tvalid && s_tready;
	assign is_write = (s_tuser == OP_WRITE);
	assign is_test  = s_tuser inside {OP_BOX, OP_SPH_OVL, OP_SPH_IN, OP_POINT};
	assign slot_plane = in_slot[SLOT_W-1:2];

	// Coefficient store: write one slot, drop slots beyond the plane count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int k = 0; k < COEF_COUNT; k++) begin
					store_q[p][k] <= '0;
				end
			end
		end else if (in_fire && is_write && (32'(slot_plane) < PLANE_COUNT)) begin
			store_q[slot_plane[PIDX_W-1:0]][in_slot[1:0]] <= in_coef;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)    v_s1    <= in_fire && is_test;
			if (en2)    v_s2    <= v_s1;
			if (en3)    v_s3    <= v_s2;
			if (en_out) out_v_q <= v_s3;
		end
	end

	// Payload registers: hold while stalled.
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= op_t'(s_tuser);
			last_s1 <= s_tlast;
			lo_s1   <= in_lo;
			hi_s1   <= in_hi;
			rad_s1  <= in_rad;
		end
		if (en2) begin
			op_s2   <= op_s1;
			last_s2 <= last_s1;
		end
		if (en3) begin
			op_s3   <= op_s2;
			last_s3 <= last_s2;
		end
	end

	lane_ctrl_t ctrl;
	lane_stat_t stat [PLANE_COUNT];
	logic       plane_ok [PLANE_COUNT];
	logic       strict_s3;
	logic       all_ok;

	assign ctrl.en_s2  = en2;
	assign ctrl.en_s3  = en3;
	assign ctrl.box_s2 = (op_s2 == OP_BOX);
	assign ctrl.r_add  = (op_s1 == OP_SPH_OVL);
	assign ctrl.r_sub  = (op_s1 == OP_SPH_IN);

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
		fct_plane_lane u_lane (
			.clk    (clk),
			.ctrl   (ctrl),
			.coef   (store_q[p]),
			.pt_lo  (lo_s1),
			.pt_hi  (hi_s1),
			.radius (rad_s1),
			.stat   (stat[p])
		);
	end

	// Box and point need a strictly positive distance; spheres accept zero.
	assign strict_s3 = (op_s3 == OP_BOX) || (op_s3 == OP_POINT);

	always_comb begin
		all_ok = 1'b1;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			plane_ok[p] = !stat[p].neg && !(strict_s3 && stat[p].zero);
			all_ok      = all_ok && plane_ok[p];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			pass_q <= all_ok;
			kind_q <= op_s3;
			last_q <= last_s3;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(TDATA_OUT_W-1){1'b0}}, pass_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

// ----- rtl/core/fct_plane_lane.sv -----
// One plane of the tester: three products per corner, per-axis selection,
// exact wide sum and sign/zero status. Depends on fct_pkg.
module fct_plane_lane (
	input  logic                            clk,
	input  fct_pkg::lane_ctrl_t             ctrl,
	input  logic signed [fct_pkg::DATA_W-1:0] coef [fct_pkg::COEF_COUNT],
	input  logic signed [fct_pkg::DATA_W-1:0] pt_lo [3],
	input  logic signed [fct_pkg::DATA_W-1:0] pt_hi [3],
	input  logic        [fct_pkg::RAD_W-1:0]  radius,
	output fct_pkg::lane_stat_t             stat
);
	import fct_pkg::*;

	logic signed [PROD_W-1:0] p_lo_s2 [3];
	logic signed [PROD_W-1:0] p_hi_s2 [3];
	logic signed [OFS_W-1:0]  ofs_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [OFS_W-1:0]  ofs_s3;

	logic signed [OFS_W-1:0]  rad_term;
	logic signed [OFS_W-1:0]  ofs_next;
	logic signed [PROD_W-1:0] pick [3];
	logic signed [SUM_W-1:0]  sum_next;
	logic signed [ACC_W-1:0]  total;

	// Offset is (w +/- r) in Q16.16; scaled to Q32.32 at the final add.
	always_comb begin
		rad_term = OFS_W'(0);
		if (ctrl.r_add) begin
			rad_term = $signed({{(OFS_W-RAD_W){1'b0}}, radius});
		end else if (ctrl.r_sub) begin
			rad_term = -$signed({{(OFS_W-RAD_W){1'b0}}, radius});
		end
		ofs_next = OFS_W'(coef[COEF_W]) + rad_term;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			for (int k = 0; k < 3; k++) begin
				p_lo_s2[k] <= pt_lo[k] * coef[k];
				p_hi_s2[k] <= pt_hi[k] * coef[k];
			end
			ofs_s2 <= ofs_next;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pick[k] = (ctrl.box_s2 && (p_hi_s2[k] > p_lo_s2[k])) ? p_hi_s2[k] : p_lo_s2[k];
		end
		sum_next = SUM_W'(pick[0]) + SUM_W'(pick[1]) + SUM_W'(pick[2]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			sum_s3 <= sum_next;
			ofs_s3 <= ofs_s2;
		end
	end

	always_comb begin
		total     = ACC_W'(sum_s3) + ACC_W'($signed({ofs_s3, {FRAC_W{1'b0}}}));
		stat.neg  = total[ACC_W-1];
		stat.zero = (total == ACC_W'(0));
	end

endmodule
